[rtl/assert_macros.svh]
// Assertion helpers used by the page-cache directory RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define SPC_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("spc assertion failed");

// Check that a condition never holds outside reset.
`define SPC_NEVER(lbl, cond) \
   `SPC_ASSERT(lbl, !(cond))

`endif

[rtl/spc_pkg.sv]
package spc_pkg;

   // Directory geometry; SHARDS must be a power of two
   localparam int SHARDS            = 16;
   localparam int ENTRIES_PER_SHARD = 8;
   localparam int PIN_BITS          = 16;

   localparam int ID_BITS    = 31;
   localparam int IDX_BITS   = (ENTRIES_PER_SHARD > 1) ? $clog2(ENTRIES_PER_SHARD) : 1;
   localparam int REC_BITS   = IDX_BITS;
   localparam int OCC_BITS   = $clog2(ENTRIES_PER_SHARD + 1);
   localparam int SHARD_BITS = (SHARDS > 1) ? $clog2(SHARDS) : 1;
   localparam int CAP_BITS   = 4;
   localparam logic [CAP_BITS-1:0] CAP_RESET = 4'd8;
   localparam logic [PIN_BITS-1:0] PIN_MAX   = '1;

   // Operation codes
   localparam logic [2:0] OP_FETCH  = 3'd0;
   localparam logic [2:0] OP_NEW    = 3'd1;
   localparam logic [2:0] OP_UNPIN  = 3'd2;
   localparam logic [2:0] OP_FLUSH  = 3'd3;
   localparam logic [2:0] OP_DELETE = 3'd4;

   // Status codes
   localparam logic [1:0] STATUS_DONE      = 2'd0;
   localparam logic [1:0] STATUS_ABSENT    = 2'd1;
   localparam logic [1:0] STATUS_NO_VICTIM = 2'd2;
   localparam logic [1:0] STATUS_PINNED    = 2'd3;

   typedef struct packed {
      logic [2:0]         op;
      logic [ID_BITS-1:0] page_id;
      logic               set_dirty;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic               hit;
      logic [ID_BITS-1:0] page_id_out;
      logic               need_read;
      logic               evict_valid;
      logic [ID_BITS-1:0] evict_page_id;
      logic               writeback_valid;
      logic [ID_BITS-1:0] writeback_page_id;
   } rsp_type;

   typedef struct packed {
      logic [ID_BITS-1:0]  tag;
      logic [PIN_BITS-1:0] pins;
      logic                dirty;
      logic [REC_BITS-1:0] rec;
   } entry_type;

   typedef entry_type [ENTRIES_PER_SHARD-1:0] row_type;

   typedef enum logic [2:0] {
      FSM_IDLE,
      FSM_READ,
      FSM_SCAN,
      FSM_UPDATE,
      FSM_RESP
   } fsm_type;

endpackage

[rtl/spc_ram.sv]
module spc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                           wr_data,
   input  logic                                       rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write one row, register the read row
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/sharded_page_cache_lru_pin.sv]
// Page-cache directory: SHARDS shards picked by page id modulo SHARDS, each a row of
// ENTRIES_PER_SHARD entries (tag, pin count, dirty, recency rank) in one RAM row.
// Each request goes through these steps before its response is offered: a read of the
// shard row, one entry at a time through a single tag/victim/free-slot compare unit, a
// build and write-back of the row, and a load of the response register, which waits
// while the output register still holds a stalled response. Requests with an unknown op
// skip the directory and go straight to the response register. req_stall stays high while
// a request is in work; a finished response waits in its own register, so a new request is
// taken while it is still stalled. capacity_per_shard may only be written while idle.
`include "assert_macros.svh"

module sharded_page_cache_lru_pin
   import spc_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  req_type             req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output rsp_type             rsp_data,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [CAP_BITS-1:0] csr_data
);

   localparam int EPS = ENTRIES_PER_SHARD;

   fsm_type fsm_ff, fsm_in;
   req_type req_ff, req_in;
   logic [ID_BITS-1:0]  next_id_ff, next_id_in;
   logic [CAP_BITS-1:0] cap_ff;
   logic [EPS-1:0]      valid_ff [SHARDS];
   logic [EPS-1:0]      valid_in [SHARDS];
   logic [OCC_BITS-1:0] occ_ff [SHARDS];
   logic [OCC_BITS-1:0] occ_in [SHARDS];
   logic [IDX_BITS-1:0] scan_ff, scan_in;
   logic                hit_found_ff, hit_found_in;
   logic [IDX_BITS-1:0] hit_idx_ff, hit_idx_in;
   logic                vic_found_ff, vic_found_in;
   logic [IDX_BITS-1:0] vic_idx_ff, vic_idx_in;
   logic [REC_BITS-1:0] vic_rec_ff, vic_rec_in;
   logic                free_found_ff, free_found_in;
   logic [IDX_BITS-1:0] free_idx_ff, free_idx_in;
   rsp_type             res_ff, res_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_ff, rsp_in;

   logic [SHARD_BITS-1:0] shard;
   logic                  ram_rd_en;
   logic                  ram_wr_en;
   logic [$bits(row_type)-1:0] ram_rd_data;
   row_type               row;
   row_type               new_row;
   entry_type             scan_e;
   entry_type             hit_e;
   entry_type             vic_e;
   logic [EPS-1:0]        row_valid;
   logic [EPS-1:0]        new_valid;
   logic [OCC_BITS-1:0]   occ;
   logic [7:0]            cap_w;
   logic                  full;
   logic                  is_fetch, is_new, is_unpin, is_flush, is_delete;
   logic                  ins_req, ins_fail, do_evict, do_ins, do_touch, do_del;
   logic [IDX_BITS-1:0]   fs_idx;

   assign shard     = SHARD_BITS'(req_ff.page_id % SHARDS);
   assign row       = row_type'(ram_rd_data);
   assign scan_e    = row[scan_ff];
   assign hit_e     = row[hit_idx_ff];
   assign vic_e     = row[vic_idx_ff];
   assign row_valid = valid_ff[shard];
   assign occ       = occ_ff[shard];

   spc_ram #(
      .WIDTH ($bits(row_type)),
      .DEPTH (SHARDS)
   ) u_row_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (shard),
      .wr_data (new_row),
      .rd_en   (ram_rd_en),
      .rd_addr (shard),
      .rd_data (ram_rd_data)
   );

   // Decode the request held for update
   always_comb begin
      is_fetch  = (req_ff.op == OP_FETCH);
      is_new    = (req_ff.op == OP_NEW);
      is_unpin  = (req_ff.op == OP_UNPIN);
      is_flush  = (req_ff.op == OP_FLUSH);
      is_delete = (req_ff.op == OP_DELETE);
      cap_w     = (8'(cap_ff) > 8'(EPS)) ? 8'(EPS) : 8'(cap_ff);
      full      = (8'(occ) >= cap_w);
      ins_req   = (is_fetch || is_new) && !hit_found_ff;
      ins_fail  = ins_req && ((full && !vic_found_ff) || (!full && !free_found_ff));
      do_ins    = ins_req && !ins_fail;
      do_evict  = do_ins && full;
      do_touch  = (is_fetch || is_new) && hit_found_ff;
      do_del    = is_delete && hit_found_ff && (hit_e.pins == '0);
      fs_idx    = (do_evict && (!free_found_ff || (vic_idx_ff < free_idx_ff)))
                  ? vic_idx_ff : free_idx_ff;
   end

   // Build the updated row, one independent update per entry
   always_comb begin
      new_row   = row;
      new_valid = row_valid;
      for (int j = 0; j < EPS; j++) begin
         if (do_touch) begin
            if (IDX_BITS'(j) == hit_idx_ff) begin
               new_row[j].rec = '0;
               if (is_fetch) begin
                  if (row[j].pins != PIN_MAX) begin
                     new_row[j].pins = row[j].pins + 1'b1;
                  end
               end else begin
                  new_row[j].pins  = PIN_BITS'(1);
                  new_row[j].dirty = 1'b0;
               end
            end else if (row_valid[j] && (row[j].rec < hit_e.rec)) begin
               new_row[j].rec = row[j].rec + 1'b1;
            end
         end
         if (do_ins) begin
            if (do_evict && (IDX_BITS'(j) == vic_idx_ff)) begin
               new_valid[j] = 1'b0;
            end else if (row_valid[j]) begin
               new_row[j].rec = row[j].rec + 1'b1
                  - REC_BITS'(do_evict && (row[j].rec > vic_rec_ff));
            end
            if (IDX_BITS'(j) == fs_idx) begin
               new_valid[j]     = 1'b1;
               new_row[j].tag   = req_ff.page_id;
               new_row[j].pins  = PIN_BITS'(1);
               new_row[j].dirty = 1'b0;
               new_row[j].rec   = '0;
            end
         end
         if (is_unpin && hit_found_ff && (IDX_BITS'(j) == hit_idx_ff)) begin
            if (row[j].pins != '0) begin
               new_row[j].pins = row[j].pins - 1'b1;
            end
            new_row[j].dirty = row[j].dirty | req_ff.set_dirty;
         end
         if (is_flush && hit_found_ff && (IDX_BITS'(j) == hit_idx_ff)) begin
            new_row[j].dirty = 1'b0;
         end
         if (do_del) begin
            if (IDX_BITS'(j) == hit_idx_ff) begin
               new_valid[j] = 1'b0;
            end else if (row_valid[j] && (row[j].rec > hit_e.rec)) begin
               new_row[j].rec = row[j].rec - 1'b1;
            end
         end
      end
   end

   // Sequencer: next state and next register values
   always_comb begin
      fsm_in        = fsm_ff;
      req_in        = req_ff;
      next_id_in    = next_id_ff;
      valid_in      = valid_ff;
      occ_in        = occ_ff;
      scan_in       = scan_ff;
      hit_found_in  = hit_found_ff;
      hit_idx_in    = hit_idx_ff;
      vic_found_in  = vic_found_ff;
      vic_idx_in    = vic_idx_ff;
      vic_rec_in    = vic_rec_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      res_in        = res_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      ram_rd_en     = 1'b0;
      ram_wr_en     = 1'b0;

      unique case (fsm_ff)
         FSM_IDLE: begin
            // Take a request; new page draws the next id
            if (req_valid) begin
               req_in = req_data;
               if (req_data.op == OP_NEW) begin
                  req_in.page_id = next_id_ff;
                  next_id_in     = next_id_ff + 1'b1;
               end
               res_in             = '0;
               res_in.status      = STATUS_DONE;
               res_in.page_id_out = req_in.page_id;
               fsm_in = (req_data.op > OP_DELETE) ? FSM_RESP : FSM_READ;
            end
         end
         FSM_READ: begin
            // Fetch the shard row, clear the scan results
            ram_rd_en     = 1'b1;
            scan_in       = '0;
            hit_found_in  = 1'b0;
            vic_found_in  = 1'b0;
            free_found_in = 1'b0;
            fsm_in        = FSM_SCAN;
         end
         FSM_SCAN: begin
            // Check one entry per cycle
            if (row_valid[scan_ff]) begin
               if (!hit_found_ff && (scan_e.tag == req_ff.page_id)) begin
                  hit_found_in = 1'b1;
                  hit_idx_in   = scan_ff;
               end
               if ((scan_e.pins == '0) && (!vic_found_ff || (scan_e.rec > vic_rec_ff))) begin
                  vic_found_in = 1'b1;
                  vic_idx_in   = scan_ff;
                  vic_rec_in   = scan_e.rec;
               end
            end else if (!free_found_ff) begin
               free_found_in = 1'b1;
               free_idx_in   = scan_ff;
            end
            scan_in = scan_ff + 1'b1;
            if (scan_ff == IDX_BITS'(EPS - 1)) begin
               fsm_in = FSM_UPDATE;
            end
         end
         FSM_UPDATE: begin
            // Write the row back and form the response
            ram_wr_en       = 1'b1;
            valid_in[shard] = new_valid;
            if (do_ins && !do_evict) begin
               occ_in[shard] = occ + 1'b1;
            end else if (do_del && (occ != '0)) begin
               occ_in[shard] = occ - 1'b1;
            end
            priority if (ins_fail) begin
               res_in.status = STATUS_NO_VICTIM;
            end else if ((is_unpin || is_flush || is_delete) && !hit_found_ff) begin
               res_in.status = STATUS_ABSENT;
            end else if (is_delete && !do_del) begin
               res_in.status = STATUS_PINNED;
            end else begin
               res_in.status = STATUS_DONE;
            end
            res_in.hit         = is_fetch && hit_found_ff;
            res_in.need_read   = is_fetch && do_ins;
            res_in.evict_valid = do_evict;
            if (do_evict) begin
               res_in.evict_page_id = vic_e.tag;
            end
            if (do_evict && vic_e.dirty) begin
               res_in.writeback_valid   = 1'b1;
               res_in.writeback_page_id = vic_e.tag;
            end else if (is_flush && hit_found_ff && hit_e.dirty) begin
               res_in.writeback_valid   = 1'b1;
               res_in.writeback_page_id = req_ff.page_id;
            end
            fsm_in = FSM_RESP;
         end
         FSM_RESP: begin
            // Hand the response over once the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               fsm_in       = FSM_IDLE;
            end
         end
         default: begin
            fsm_in = FSM_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         fsm_ff       <= FSM_IDLE;
         next_id_ff   <= '0;
         cap_ff       <= CAP_RESET;
         rsp_valid_ff <= 1'b0;
         for (int s = 0; s < SHARDS; s++) begin
            valid_ff[s] <= '0;
            occ_ff[s]   <= '0;
         end
      end else begin
         fsm_ff       <= fsm_in;
         next_id_ff   <= next_id_in;
         rsp_valid_ff <= rsp_valid_in;
         valid_ff     <= valid_in;
         occ_ff       <= occ_in;
         if (csr_valid) begin
            cap_ff <= csr_data;
         end
      end
   end

   // Payload and scan registers
   always_ff @(posedge clock) begin
      req_ff        <= req_in;
      scan_ff       <= scan_in;
      hit_found_ff  <= hit_found_in;
      hit_idx_ff    <= hit_idx_in;
      vic_found_ff  <= vic_found_in;
      vic_idx_ff    <= vic_idx_in;
      vic_rec_ff    <= vic_rec_in;
      free_found_ff <= free_found_in;
      free_idx_ff   <= free_idx_in;
      res_ff        <= res_in;
      rsp_ff        <= rsp_in;
   end

   assign req_stall = (fsm_ff != FSM_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign csr_ready = 1'b1;

   `SPC_ASSERT(a_occ_matches_valid,
      (fsm_ff == FSM_RESP) && $past(fsm_ff == FSM_UPDATE) |->
         ($countones(valid_ff[shard]) == int'(occ_ff[shard])))
   `SPC_NEVER(a_hit_and_insert,
      rsp_valid_ff && rsp_ff.hit && (rsp_ff.need_read || rsp_ff.evict_valid))
   `SPC_ASSERT(a_fail_no_change,
      (fsm_ff == FSM_UPDATE) && ins_fail |=> (valid_ff[shard] == $past(valid_ff[shard])))

endmodule

[bench/spc_checker.sv]
module spc_checker
   import spc_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_stall,
   input  req_type             req_data,
   input  logic                rsp_valid,
   input  logic                rsp_stall,
   input  rsp_type             rsp_data,
   input  logic                csr_valid,
   input  logic                csr_ready,
   input  logic [CAP_BITS-1:0] csr_data,
   output int                  fail_count,
   output int                  pending_count,
   output int                  rsp_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SLOTS = SHARDS * ENTRIES_PER_SHARD;

   // shadow directory
   logic                dir_valid [SLOTS];
   logic [ID_BITS-1:0]  dir_tag   [SLOTS];
   logic [PIN_BITS-1:0] dir_pins  [SLOTS];
   logic                dir_dirty [SLOTS];
   int                  dir_rank  [SLOTS];
   int                  shard_fill [SHARDS];
   logic [ID_BITS-1:0]  next_id;
   logic [CAP_BITS-1:0] capacity;

   rsp_type expected_rsps [$];

   task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
      $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
      fail_count++;
   endtask

   function automatic int find_page(input int base, input logic [ID_BITS-1:0] id);
      for (int i = base; i < base + ENTRIES_PER_SHARD; i++)
         if (dir_valid[i] && dir_tag[i] == id) return i;
      return -1;
   endfunction

   function automatic void make_recent(input int base, input int slot);
      int r;
      r = dir_rank[slot];
      for (int i = base; i < base + ENTRIES_PER_SHARD; i++)
         if (dir_valid[i] && dir_rank[i] < r) dir_rank[i]++;
      dir_rank[slot] = 0;
   endfunction

   function automatic void drop_page(input int shard, input int base, input int slot);
      int r;
      r = dir_rank[slot];
      dir_valid[slot] = 1'b0;
      for (int i = base; i < base + ENTRIES_PER_SHARD; i++)
         if (dir_valid[i] && dir_rank[i] > r) dir_rank[i]--;
      if (shard_fill[shard] > 0) shard_fill[shard]--;
   endfunction

   // insert a page, evicting the least recent unpinned one when full
   function automatic logic [1:0] insert_page(input int shard, input logic [ID_BITS-1:0] id,
                                              inout rsp_type r);
      int base, lim, victim, free_slot;
      base = shard * ENTRIES_PER_SHARD;
      lim = (capacity > ENTRIES_PER_SHARD) ? ENTRIES_PER_SHARD : int'(capacity);
      victim = -1;
      free_slot = -1;
      if (shard_fill[shard] >= lim) begin
         for (int i = base; i < base + ENTRIES_PER_SHARD; i++)
            if (dir_valid[i] && dir_pins[i] == 0 &&
                (victim < 0 || dir_rank[i] > dir_rank[victim])) victim = i;
         if (victim < 0) return STATUS_NO_VICTIM;
         r.evict_valid = 1'b1;
         r.evict_page_id = dir_tag[victim];
         if (dir_dirty[victim]) begin
            r.writeback_valid = 1'b1;
            r.writeback_page_id = dir_tag[victim];
         end
         drop_page(shard, base, victim);
      end
      for (int i = base; i < base + ENTRIES_PER_SHARD; i++)
         if (!dir_valid[i] && free_slot < 0) free_slot = i;
      if (free_slot < 0) return STATUS_NO_VICTIM;
      for (int i = base; i < base + ENTRIES_PER_SHARD; i++)
         if (dir_valid[i]) dir_rank[i]++;
      dir_valid[free_slot] = 1'b1;
      dir_tag[free_slot] = id;
      dir_pins[free_slot] = PIN_BITS'(1);
      dir_dirty[free_slot] = 1'b0;
      dir_rank[free_slot] = 0;
      shard_fill[shard]++;
      return STATUS_DONE;
   endfunction

   function automatic rsp_type predict_directory(input req_type q);
      rsp_type r;
      logic [ID_BITS-1:0] id;
      int shard, base, s;
      r = '0;
      id = q.page_id;
      if (q.op == OP_NEW) begin
         id = next_id;
         next_id = next_id + 1'b1;
      end
      r.page_id_out = id;
      if (q.op > OP_DELETE) return r;
      shard = id % SHARDS;
      base = shard * ENTRIES_PER_SHARD;
      s = find_page(base, id);
      case (q.op)
         OP_FETCH: begin
            if (s >= 0) begin
               if (dir_pins[s] != PIN_MAX) dir_pins[s]++;
               make_recent(base, s);
               r.hit = 1'b1;
            end else begin
               r.status = insert_page(shard, id, r);
               r.need_read = (r.status == STATUS_DONE);
            end
         end
         OP_NEW: begin
            if (s >= 0) begin
               dir_pins[s] = PIN_BITS'(1);
               dir_dirty[s] = 1'b0;
               make_recent(base, s);
            end else begin
               r.status = insert_page(shard, id, r);
            end
         end
         OP_UNPIN: begin
            if (s < 0) r.status = STATUS_ABSENT;
            else begin
               if (dir_pins[s] != 0) dir_pins[s]--;
               if (q.set_dirty) dir_dirty[s] = 1'b1;
            end
         end
         OP_FLUSH: begin
            if (s < 0) r.status = STATUS_ABSENT;
            else if (dir_dirty[s]) begin
               r.writeback_valid = 1'b1;
               r.writeback_page_id = id;
               dir_dirty[s] = 1'b0;
            end
         end
         default: begin
            if (s < 0) r.status = STATUS_ABSENT;
            else if (dir_pins[s] != 0) r.status = STATUS_PINNED;
            else drop_page(shard, base, s);
         end
      endcase
      return r;
   endfunction

   assign pending_count = expected_rsps.size();

   // predict on each accepted request, compare each accepted response
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) dir_valid[i] = 1'b0;
         for (int i = 0; i < SHARDS; i++) shard_fill[i] = 0;
         next_id = '0;
         capacity = CAP_RESET;
         expected_rsps.delete();
         fail_count = 0;
         rsp_count = 0;
      end else begin
         if (csr_valid && csr_ready) capacity = csr_data;
         if (req_valid && !req_stall) expected_rsps.push_back(predict_directory(req_data));
         if (rsp_valid && !rsp_stall) begin
            rsp_count++;
            if (expected_rsps.size() == 0)
               report("unexpected response", 64'(rsp_data.page_id_out), 64'd0);
            else begin
               want = expected_rsps.pop_front();
               if (rsp_data.status !== want.status)
                  report("status", 64'(rsp_data.status), 64'(want.status));
               if (rsp_data.hit !== want.hit)
                  report("hit", 64'(rsp_data.hit), 64'(want.hit));
               if (rsp_data.page_id_out !== want.page_id_out)
                  report("page_id_out", 64'(rsp_data.page_id_out), 64'(want.page_id_out));
               if (rsp_data.need_read !== want.need_read)
                  report("need_read", 64'(rsp_data.need_read), 64'(want.need_read));
               if (rsp_data.evict_valid !== want.evict_valid)
                  report("evict_valid", 64'(rsp_data.evict_valid), 64'(want.evict_valid));
               if (rsp_data.evict_page_id !== want.evict_page_id)
                  report("evict_page_id", 64'(rsp_data.evict_page_id),
                         64'(want.evict_page_id));
               if (rsp_data.writeback_valid !== want.writeback_valid)
                  report("writeback_valid", 64'(rsp_data.writeback_valid),
                         64'(want.writeback_valid));
               if (rsp_data.writeback_page_id !== want.writeback_page_id)
                  report("writeback_page_id", 64'(rsp_data.writeback_page_id),
                         64'(want.writeback_page_id));
            end
         end
      end
   end
endmodule

[bench/tb_sharded_page_cache_lru_pin.sv]
module tb_sharded_page_cache_lru_pin;
   import spc_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 400000;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   req_type             req_data = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   rsp_type             rsp_data;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [CAP_BITS-1:0] csr_data = '0;
   int                  fail_count, pending_count, rsp_count;
   int                  cycle_count = 0;
   int                  hold_off = 0;
   logic                hold_start = 1'b0;
   int                  sent = 0;
   logic [ID_BITS-1:0]  hot_ids [32];

   sharded_page_cache_lru_pin u_dut (.*);

   spc_checker u_checker (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // end the run if it hangs
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_sharded_page_cache_lru_pin: FAIL");
         $finish;
      end
   end

   // stall responses on a pattern, with a long hold-off when asked
   always @(posedge clock) begin
      if (hold_start) begin
         hold_off <= 400;
         rsp_stall <= 1'b1;
      end else if (hold_off > 0) begin
         hold_off <= hold_off - 1;
         rsp_stall <= 1'b1;
      end else if (cycle_count % 2000 < 700) rsp_stall <= 1'b0;
      else rsp_stall <= ($urandom_range(0, 3) == 0);
   end

   // offer one request and wait until it is taken
   task automatic send_request(input logic [2:0] op, input logic [ID_BITS-1:0] id,
                               input logic dirty);
      req_valid <= 1'b1;
      req_data <= '{op: op, page_id: id, set_dirty: dirty};
      do @(posedge clock); while (req_stall);
      sent++;
   endtask

   task automatic idle_gap(input int n);
      req_valid <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [CAP_BITS-1:0] value);
      drain();
      csr_valid <= 1'b1;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // mostly pages from a small hot set so shards fill and evict
   task automatic random_request();
      logic [2:0]         op;
      logic [ID_BITS-1:0] id;
      int                 pick;
      pick = $urandom_range(0, 99);
      if (pick < 40) op = OP_FETCH;
      else if (pick < 50) op = OP_NEW;
      else if (pick < 75) op = OP_UNPIN;
      else if (pick < 85) op = OP_FLUSH;
      else if (pick < 97) op = OP_DELETE;
      else op = 3'($urandom_range(5, 7));
      if ($urandom_range(0, 9) == 0) id = ID_BITS'($urandom());
      else id = hot_ids[$urandom_range(0, 31)];
      send_request(op, id, 1'($urandom_range(0, 1)));
   endtask

   initial begin
      foreach (hot_ids[i])
         hot_ids[i] = (i < 16) ? ID_BITS'(i * SHARDS + 3) :
                      ID_BITS'($urandom() & 32'h7fff_fff0) | ID_BITS'(i % 4);
      hot_ids[31] = '1;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes of ids, every op, pin and dirty cases
      send_request(OP_FETCH, '0, 1'b0);
      send_request(OP_FETCH, '0, 1'b0);
      send_request(OP_FETCH, '1, 1'b1);
      send_request(OP_UNPIN, '0, 1'b1);
      send_request(OP_UNPIN, '0, 1'b0);
      send_request(OP_UNPIN, '0, 1'b0);
      send_request(OP_FLUSH, '0, 1'b0);
      send_request(OP_FLUSH, '0, 1'b0);
      send_request(OP_DELETE, '1, 1'b0);
      send_request(OP_DELETE, '0, 1'b0);
      send_request(OP_DELETE, '0, 1'b0);
      send_request(OP_UNPIN, 31'h5555_5555, 1'b1);
      send_request(OP_FLUSH, 31'h2aaa_aaaa, 1'b0);
      send_request(OP_NEW, '1, 1'b1);
      send_request(OP_NEW, '0, 1'b0);
      send_request(3'd5, 31'h1234_5678, 1'b1);
      send_request(3'd7, '1, 1'b0);
      // fill shard 0 with pinned pages, then miss with no victim
      write_capacity(4'd2);
      send_request(OP_FETCH, 31'd16, 1'b0);
      send_request(OP_FETCH, 31'd32, 1'b0);
      send_request(OP_FETCH, 31'd48, 1'b0);
      send_request(OP_UNPIN, 31'd16, 1'b1);
      send_request(OP_FETCH, 31'd48, 1'b0);
      // zero capacity: every miss needs a victim
      write_capacity(4'd0);
      send_request(OP_FETCH, 31'd64, 1'b0);
      send_request(OP_FETCH, 31'd32, 1'b0);

      // random phases over several capacities, extremes among them
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: write_capacity(4'd8);
            1: write_capacity(4'd15);
            2: write_capacity(4'd1);
            3: write_capacity(4'd3);
            4: write_capacity(4'd0);
            default: write_capacity(4'd8);
         endcase
         for (int n = 0; n < 215; ) begin
            int burst;
            burst = $urandom_range(1, 12);
            for (int b = 0; b < burst && n < 215; b++, n++) random_request();
            if ($urandom_range(0, 2) != 0) idle_gap($urandom_range(1, 25));
         end
         // hold off responses so the block backs up its input
         if (phase == 2) begin
            hold_start <= 1'b1;
            @(posedge clock);
            hold_start <= 1'b0;
            for (int b = 0; b < 8; b++) random_request();
         end
         // pause until everything is back
         if (phase == 3) drain();
      end

      drain();
      repeat (30) @(posedge clock);
      $display("Sent %0d requests across six capacity settings (0 to 15), %0d responses checked.",
               sent, rsp_count);
      if (fail_count == 0 && pending_count == 0)
         $display("tb_sharded_page_cache_lru_pin: PASS");
      else
         $display("tb_sharded_page_cache_lru_pin: FAIL");
      $finish;
   end
endmodule

[filelist.f]
+incdir+rtl
rtl/spc_pkg.sv
rtl/spc_ram.sv
rtl/sharded_page_cache_lru_pin.sv
bench/spc_checker.sv
bench/tb_sharded_page_cache_lru_pin.sv
